// ----- hdl/rdz_pkg.sv -----
// ----------------------------------------------------------------------------
// rdz_pkg
// Shared constants for the radial dead zone rescaler.
// ----------------------------------------------------------------------------
`default_nettype none

package rdz_pkg;

  // fraction bits kept below the magnitude
  localparam int GUARD_BITS = 8;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_INNER = 1'b0,
    REG_OUTER = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

// ----- hdl/radial_dead_zone_rescale.sv -----
// ----------------------------------------------------------------------------
// radial_dead_zone_rescale
// Radial scaled dead zone for a two-axis stick sample, fully pipelined.
// ----------------------------------------------------------------------------
// Input words carry raw_x and raw_y; output words carry the corrected x, y
// and the length of the corrected vector. Two thresholds are set through
// the cfg port while the block is idle; the user must keep to this, as the
// block does not enforce it. The pipeline has three setup stages, a root
// stage per magnitude bit (SAMPLE_BITS + 8), one for the scale prep, a scale
// divider of SAMPLE_BITS stages, two stages for the scale product, a
// component divider of SAMPLE_BITS stages and the output register. One word
// is taken every cycle unless the receiver stalls. Reset empties the pipeline
// and loads the thresholds with 0 and full deflection. When the receiver
// stalls the whole pipeline holds and in_tready drops in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module radial_dead_zone_rescale #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_wen,
  input  wire logic                                   cfg_index,
  input  wire logic [SAMPLE_BITS-1:0]                 cfg_wdata,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  // raw_x, raw_y
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // corrected_x, corrected_y, corrected_magnitude
  output logic [((3*SAMPLE_BITS+7)/8)*8-1:0]          out_tdata
);
  import rdz_pkg::*;

  localparam int S   = SAMPLE_BITS;
  localparam int G   = GUARD_BITS;
  localparam int W   = S + G;
  localparam int IDW = ((2*S+7)/8)*8;
  localparam int ODW = ((3*S+7)/8)*8;
  localparam int SQS = 2*S + 4;
  localparam int SDS = 2*S + 4 + W;
  localparam int CXS = S + 2;
  localparam logic [S-1:0] FULL = S'(1) << (S-1);

  logic adv;
  logic [S-1:0] inner_r, outer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= '0;
      outer_r <= FULL;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_INNER: inner_r <= cfg_wdata;
        REG_OUTER: outer_r <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // stage 1: magnitudes
  logic         v1_r, nx1_r, ny1_r;
  logic [S-1:0] ax1_r, ay1_r;
  logic [S-1:0] rx, ry;

  assign rx = in_tdata[S-1:0];
  assign ry = in_tdata[2*S-1:S];

  // stage 2: squares
  logic           v2_r, nx2_r, ny2_r;
  logic [S-1:0]   ax2_r, ay2_r;
  logic [2*S-1:0] sqx2_r, sqy2_r, in2_r, out2_r;

  // stage 3: zone tests
  logic           v3_r, nx3_r, ny3_r, zero3_r, outz3_r;
  logic [S-1:0]   ax3_r, ay3_r;
  logic [2*S-1:0] q3_nxt, q3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign q3_nxt = sqx2_r + sqy2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      nx1_r   <= rx[S-1];
      ny1_r   <= ry[S-1];
      ax1_r   <= rx[S-1] ? S'(~rx + 1'b1) : rx;
      ay1_r   <= ry[S-1] ? S'(~ry + 1'b1) : ry;
      nx2_r   <= nx1_r;
      ny2_r   <= ny1_r;
      ax2_r   <= ax1_r;
      ay2_r   <= ay1_r;
      sqx2_r  <= (2*S)'(ax1_r) * (2*S)'(ax1_r);
      sqy2_r  <= (2*S)'(ay1_r) * (2*S)'(ay1_r);
      in2_r   <= (2*S)'(inner_r) * (2*S)'(inner_r);
      out2_r  <= (2*S)'(outer_r) * (2*S)'(outer_r);
      nx3_r   <= nx2_r;
      ny3_r   <= ny2_r;
      ax3_r   <= ax2_r;
      ay3_r   <= ay2_r;
      q3_r    <= q3_nxt;
      zero3_r <= (q3_nxt == '0) || (q3_nxt < in2_r);
      outz3_r <= (q3_nxt > out2_r);
    end
  end

  // magnitude with guard bits
  logic           vq;
  logic [W-1:0]   mq;
  logic [SQS-1:0] sq_side;

  rdz_sqrt #(.RW(W), .SW(SQS)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v3_r),
    .in_val   ({q3_r, {(2*G){1'b0}}}),
    .in_side  ({ax3_r, ay3_r, nx3_r, ny3_r, zero3_r, outz3_r}),
    .out_valid(vq),
    .out_root (mq),
    .out_side (sq_side)
  );

  // stage 4: scale divider operands
  logic           v4_r, zero4_r;
  logic [S+W:0]   num4_r;
  logic [W:0]     den4_r;
  logic [SDS-1:0] side4_r;
  logic [W-1:0]   d4, t4;

  assign d4 = {S'(outer_r - inner_r), {G{1'b0}}};
  assign t4 = mq - {inner_r, {G{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num4_r  <= {1'b0, t4, {S{1'b0}}} + (S+W+1)'(d4);
      den4_r  <= {d4, 1'b0};
      zero4_r <= sq_side[1] || (!sq_side[0] && (outer_r <= inner_r));
      side4_r <= {sq_side[SQS-1:2], 1'b0, sq_side[0], mq};
    end
  end

  logic           vs;
  logic [S-1:0]   sq;
  logic [SDS-1:0] sd_side;

  rdz_div #(.NW(S+W+1), .DW(W+1), .QW(S), .SW(SDS)) u_sdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v4_r),
    .in_num   (num4_r),
    .in_den   (den4_r),
    .in_side  ({side4_r[SDS-1:W+2], zero4_r, side4_r[W:0]}),
    .out_valid(vs),
    .out_quot (sq),
    .out_side (sd_side)
  );

  // stage 5: final scale
  logic         v5_r, nx5_r, ny5_r, zero5_r;
  logic [S-1:0] ax5_r, ay5_r, s5_r;
  logic [W-1:0] m5_r;

  // stage 6: scale products
  logic           v6_r, nx6_r, ny6_r, zero6_r;
  logic [S-1:0]   s6_r;
  logic [W-1:0]   m6_r;
  logic [2*S-1:0] px6_r, py6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v5_r <= vs;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax5_r   <= sd_side[SDS-1 -: S];
      ay5_r   <= sd_side[SDS-1-S -: S];
      nx5_r   <= sd_side[W+3];
      ny5_r   <= sd_side[W+2];
      zero5_r <= sd_side[W+1];
      m5_r    <= sd_side[W-1:0];
      s5_r    <= (sd_side[W] || (sq > FULL)) ? FULL : sq;
      nx6_r   <= nx5_r;
      ny6_r   <= ny5_r;
      zero6_r <= zero5_r;
      s6_r    <= s5_r;
      m6_r    <= m5_r;
      px6_r   <= (2*S)'(ax5_r) * (2*S)'(s5_r);
      py6_r   <= (2*S)'(ay5_r) * (2*S)'(s5_r);
    end
  end

  // component dividers
  logic           vcx, vcy;
  logic [S-1:0]   cqx, cqy;
  logic [CXS-1:0] cx_side;
  logic           cy_side;

  rdz_div #(.NW(2*S+G+1), .DW(W+1), .QW(S), .SW(CXS)) u_xdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v6_r),
    .in_num   ({px6_r, {(G+1){1'b0}}} + (2*S+G+1)'(m6_r)),
    .in_den   ({m6_r, 1'b0}),
    .in_side  ({nx6_r, zero6_r, s6_r}),
    .out_valid(vcx),
    .out_quot (cqx),
    .out_side (cx_side)
  );

  rdz_div #(.NW(2*S+G+1), .DW(W+1), .QW(S), .SW(1)) u_ydiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v6_r),
    .in_num   ({py6_r, {(G+1){1'b0}}} + (2*S+G+1)'(m6_r)),
    .in_den   ({m6_r, 1'b0}),
    .in_side  (ny6_r),
    .out_valid(vcy),
    .out_quot (cqy),
    .out_side (cy_side)
  );

  // output register: sign and saturation
  logic         out_zero;
  logic [S-1:0] ox_nxt, oy_nxt, om_nxt;
  logic [S-1:0] ox_r, oy_r, om_r;
  logic         ov_r;

  assign out_zero = cx_side[S];

  always_comb begin
    if (cx_side[S+1]) begin
      ox_nxt = (cqx > FULL) ? FULL : S'(~cqx + 1'b1);
    end else begin
      ox_nxt = (cqx > FULL - 1'b1) ? S'(FULL - 1'b1) : cqx;
    end
    if (cy_side) begin
      oy_nxt = (cqy > FULL) ? FULL : S'(~cqy + 1'b1);
    end else begin
      oy_nxt = (cqy > FULL - 1'b1) ? S'(FULL - 1'b1) : cqy;
    end
    om_nxt = cx_side[S-1:0];
    if (out_zero) begin
      ox_nxt = '0;
      oy_nxt = '0;
      om_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= vcx;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
      om_r <= om_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = ODW'({om_r, oy_r, ox_r});

  // checks
  a_lanes_agree : assert property (@(posedge clk) disable iff (!rst_n)
    vcx == vcy) else $error("component lanes out of step");

  a_mag_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (om_r <= FULL)) else $error("magnitude above full scale");

  a_zero_mag : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && om_r == '0) |-> (ox_r == '0 && oy_r == '0))
    else $error("nonzero component with zero magnitude");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("output valid after reset");

endmodule

`default_nettype wire

// ----- hdl/rdz_sqrt.sv -----
// ----------------------------------------------------------------------------
// rdz_sqrt
// Pipelined integer square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module rdz_sqrt #(
  parameter int RW = 24,
  parameter int SW = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [2*RW-1:0]   in_val,
  input  wire logic [SW-1:0]     in_side,
  output logic                   out_valid,
  output logic [RW-1:0]          out_root,
  output logic [SW-1:0]          out_side
);
  import rdz_pkg::*;

  logic [RW+1:0]   rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [2*RW-1:0] val_r  [RW];
  logic [SW-1:0]   side_r [RW];
  logic            vld_r  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [RW+1:0]   p_rem;
    logic [RW-1:0]   p_root;
    logic [2*RW-1:0] p_val;
    logic [SW-1:0]   p_side;
    logic            p_vld;
    logic [RW+3:0]   r2;
    logic [RW+3:0]   trial;
    logic            ge;

    if (i == 0) begin : g_first
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_val  = in_val;
      assign p_side = in_side;
      assign p_vld  = in_valid;
    end else begin : g_next
      assign p_rem  = rem_r[i-1];
      assign p_root = root_r[i-1];
      assign p_val  = val_r[i-1];
      assign p_side = side_r[i-1];
      assign p_vld  = vld_r[i-1];
    end

    assign r2    = {p_rem, p_val[2*RW-1 -: 2]};
    assign trial = {2'b00, p_root, 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? (RW+2)'(r2 - trial) : (RW+2)'(r2);
        root_r[i] <= {p_root[RW-2:0], ge};
        val_r[i]  <= {p_val[2*RW-3:0], 2'b00};
        side_r[i] <= p_side;
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

`default_nettype wire

// ----- hdl/rdz_div.sv -----
// ----------------------------------------------------------------------------
// rdz_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Quotient must fit in QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rdz_div #(
  parameter int NW = 41,
  parameter int DW = 25,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic [NW-1:0]  in_num,
  input  wire logic [DW-1:0]  in_den,
  input  wire logic [SW-1:0]  in_side,
  output logic                out_valid,
  output logic [QW-1:0]       out_quot,
  output logic [SW-1:0]       out_side
);
  import rdz_pkg::*;

  logic [DW-1:0] rem_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] lo_r   [QW];
  logic [QW-1:0] quot_r [QW];
  logic [SW-1:0] side_r [QW];
  logic          vld_r  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0] p_rem;
    logic [DW-1:0] p_den;
    logic [QW-1:0] p_lo;
    logic [QW-1:0] p_quot;
    logic [SW-1:0] p_side;
    logic          p_vld;
    logic [DW:0]   r2;
    logic          ge;

    if (i == 0) begin : g_first
      assign p_rem  = DW'(in_num >> QW);
      assign p_den  = in_den;
      assign p_lo   = in_num[QW-1:0];
      assign p_quot = '0;
      assign p_side = in_side;
      assign p_vld  = in_valid;
    end else begin : g_next
      assign p_rem  = rem_r[i-1];
      assign p_den  = den_r[i-1];
      assign p_lo   = lo_r[i-1];
      assign p_quot = quot_r[i-1];
      assign p_side = side_r[i-1];
      assign p_vld  = vld_r[i-1];
    end

    assign r2 = {p_rem, p_lo[QW-1]};
    assign ge = (r2 >= {1'b0, p_den});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? DW'(r2 - {1'b0, p_den}) : DW'(r2);
        den_r[i]  <= p_den;
        lo_r[i]   <= {p_lo[QW-2:0], 1'b0};
        quot_r[i] <= {p_quot[QW-2:0], ge};
        side_r[i] <= p_side;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quot  = quot_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

`default_nettype wire
